/* rtl/core/rsp_pkg.sv */
// rsp_pkg: types and constants shared by the RESP stream parser.
// No dependencies.
package rsp_pkg;

    typedef enum logic [2:0] {
        PH_TYPE    = 3'd0,
        PH_LEN     = 3'd1,
        PH_LINE    = 3'd2,
        PH_BULK    = 3'd3,
        PH_BULKEND = 3'd4,
        PH_ERROR   = 3'd5
    } t_phase;

    localparam logic [2:0] ET_ARRAY  = 3'd0;
    localparam logic [2:0] ET_BULK   = 3'd1;
    localparam logic [2:0] ET_SIMPLE = 3'd2;
    localparam logic [2:0] ET_ERROR  = 3'd3;
    localparam logic [2:0] ET_NULL   = 3'd4;

    localparam logic [2:0] ERR_NONE   = 3'd0;
    localparam logic [2:0] ERR_TYPE   = 3'd1;
    localparam logic [2:0] ERR_LENGTH = 3'd2;
    localparam logic [2:0] ERR_DEPTH  = 3'd3;
    localparam logic [2:0] ERR_NEG    = 3'd4;

    localparam logic [7:0] CH_STAR  = 8'h2A;
    localparam logic [7:0] CH_DOLLR = 8'h24;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;

    localparam logic [30:0] LEN_MAX = 31'h7FFF_FFFF;

    typedef struct packed {
        logic [7:0] stream_byte;
        logic       resync;
    } t_in;

    typedef struct packed {
        logic              payload_valid;
        logic [7:0]        payload_byte;
        logic              elem_start;
        logic [2:0]        elem_type;
        logic              elem_done;
        logic signed [31:0] length_value;
        logic [4:0]        nest_depth;
        logic              value_done;
        logic [2:0]        error_code;
        logic              last_of_run;
    } t_out;

    // queue entry: up to two results from one byte
    typedef struct packed {
        logic  two;
        t_out  r0;
        t_out  r1;
    } t_ent;

endpackage

/* rtl/core/resp_stream_parser_top.sv */
// resp_stream_parser_top: RESP2 byte-stream parser, front parse engine plus result queue.
// Depends on rsp_pkg, rsp_front, rsp_back.
//
//  channel | signals                          | payload
//  in      | i_in_valid / o_in_ready          | rsp_pkg::t_in  (stream_byte, resync)
//  out     | o_out_valid / i_out_ready        | rsp_pkg::t_out (result fields)
//
// One byte per cycle enters while the two-entry queue has room; a byte with two
// results occupies the output for two beats. Array completions cascade in the
// same cycle through per-level "one left" flags. Reset clears parse state and
// the queue; the element-count stack holds no reset. Output stalls back up the
// queue and then the input.
module resp_stream_parser_top #(
    parameter int MAX_DEPTH = 16
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    input  rsp_pkg::t_in  i_in_data,
    output logic          o_in_ready,
    output logic          o_out_valid,
    output rsp_pkg::t_out o_out_data,
    input  logic          i_out_ready
);
    import rsp_pkg::*;

    logic push, space;
    t_ent ent;

    rsp_front #(.MAX_DEPTH(MAX_DEPTH)) u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_in_valid), .i_data(i_in_data),
        .o_ready(o_in_ready), .o_push(push), .o_ent(ent), .i_space(space)
    );

    rsp_back u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_push(push), .i_ent(ent),
        .o_space(space), .o_valid(o_out_valid), .o_data(o_out_data),
        .i_ready(i_out_ready)
    );
endmodule

/* rtl/core/rsp_front.sv */
// rsp_front: per-byte parse engine, produces at most one queue entry per byte.
// Depends on rsp_pkg.
module rsp_front #(
    parameter int MAX_DEPTH = 16
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    input  rsp_pkg::t_in  i_data,
    output logic          o_ready,
    output logic          o_push,
    output rsp_pkg::t_ent o_ent,
    input  logic          i_space
);
    import rsp_pkg::*;

    localparam int SPW = $clog2(MAX_DEPTH + 1);
    localparam int IW  = (MAX_DEPTH > 1) ? $clog2(MAX_DEPTH) : 1;

    t_phase      r_ph, n_ph;
    logic [2:0]  r_ty, n_ty;
    logic [30:0] r_acc, n_acc;
    logic        r_neg, n_neg;
    logic        r_dig, n_dig;
    logic [30:0] r_bulk, n_bulk;
    logic        r_cr, n_cr;
    logic [SPW-1:0] r_sp, n_sp;
    logic [2:0]  r_err, n_err;
    logic [30:0] r_stk [MAX_DEPTH];
    // cascade: levels with remaining==1 from top; kept as a per-level flag
    logic [MAX_DEPTH-1:0] r_one;

    logic        acc;
    logic [7:0]  b;
    logic        fin;
    logic        fin_vd;
    logic [SPW-1:0] fin_sp;
    logic        push_stk;
    logic [34:0] prod;
    logic [3:0]  dv;
    logic        n_dec;
    t_out        e0, e1;
    logic        two, any;

    assign o_ready = i_space;
    assign acc = i_valid & i_space;
    assign b = i_data.stream_byte;

    // completion cascade: pop all consecutive "one left" levels from the top
    always_comb begin
        fin_sp = r_sp;
        for (int k = MAX_DEPTH - 1; k >= 0; k--) begin
            if (fin_sp == SPW'(k + 1) && r_one[k]) fin_sp = SPW'(k);
        end
        fin_vd = (fin_sp == '0);
    end

    always_comb begin
        n_ph = r_ph; n_ty = r_ty; n_acc = r_acc; n_neg = r_neg; n_dig = r_dig;
        n_bulk = r_bulk; n_cr = r_cr; n_sp = r_sp; n_err = r_err;
        fin = 1'b0; push_stk = 1'b0; n_dec = 1'b0;
        e0 = '0; e1 = '0; two = 1'b0; any = 1'b0;
        dv = 4'(b - CH_ZERO);
        // acc*10 + digit, wide enough to see the overflow past LEN_MAX
        prod = {1'b0, r_acc, 3'b0} + {3'b0, r_acc, 1'b0} + 35'(dv);
        case (r_ph)
            PH_TYPE: begin
                n_acc = '0; n_neg = 1'b0; n_dig = 1'b0; n_cr = 1'b0;
                any = 1'b1;
                e0.elem_start = 1'b1;
                case (b)
                    CH_STAR:  begin n_ty = ET_ARRAY;  n_ph = PH_LEN;  end
                    CH_DOLLR: begin n_ty = ET_BULK;   n_ph = PH_LEN;  end
                    CH_PLUS, CH_COLON: begin n_ty = ET_SIMPLE; n_ph = PH_LINE; end
                    CH_MINUS: begin n_ty = ET_ERROR;  n_ph = PH_LINE; end
                    default: begin
                        n_err = ERR_TYPE; n_ph = PH_ERROR; e0.elem_start = 1'b0;
                    end
                endcase
                if (n_ph != PH_ERROR) e0.elem_type = n_ty;
            end
            PH_LEN: begin
                if (r_cr) begin
                    any = 1'b1;
                    n_cr = 1'b0;
                    if (b != CH_LF || !r_dig) begin
                        n_err = ERR_LENGTH; n_ph = PH_ERROR;
                    end else if (r_ty == ET_ARRAY) begin
                        if (r_neg || r_acc == '0) begin
                            n_ph = PH_TYPE; fin = 1'b1; e0.elem_done = 1'b1;
                            e0.value_done = fin_vd;
                        end else if (r_sp >= SPW'(MAX_DEPTH)) begin
                            n_err = ERR_DEPTH; n_ph = PH_ERROR;
                        end else begin
                            push_stk = 1'b1; n_sp = r_sp + 1'b1; n_ph = PH_TYPE;
                            e0.elem_done = 1'b1;
                            e0.length_value = {1'b0, r_acc};
                        end
                    end else if (r_neg && r_acc != '0) begin
                        if (r_acc != 31'd1) begin
                            n_err = ERR_NEG; n_ph = PH_ERROR;
                        end else begin
                            n_ph = PH_TYPE; fin = 1'b1;
                            e0.elem_type = ET_NULL; e0.elem_done = 1'b1;
                            e0.length_value = -32'sd1;
                            e0.value_done = fin_vd;
                        end
                    end else begin
                        any = 1'b0;
                        if (r_acc == '0) n_ph = PH_BULKEND;
                        else begin n_bulk = r_acc; n_ph = PH_BULK; end
                    end
                end else if (b == CH_CR) begin
                    n_cr = 1'b1;
                end else if (b == CH_MINUS && !r_dig && !r_neg) begin
                    n_neg = 1'b1;
                end else if (b inside {[CH_ZERO:CH_NINE]}) begin
                    if (prod > 35'(LEN_MAX)) begin
                        any = 1'b1; n_err = ERR_LENGTH; n_ph = PH_ERROR;
                    end else begin
                        n_acc = prod[30:0];
                        n_dig = 1'b1;
                    end
                end else begin
                    any = 1'b1; n_err = ERR_LENGTH; n_ph = PH_ERROR;
                end
            end
            PH_LINE: begin
                e0.elem_type = r_ty; e1.elem_type = r_ty;
                if (r_cr) begin
                    any = 1'b1;
                    if (b == CH_LF) begin
                        n_cr = 1'b0; n_ph = PH_TYPE; fin = 1'b1;
                        e0.elem_done = 1'b1; e0.value_done = fin_vd;
                    end else begin
                        e0.payload_valid = 1'b1; e0.payload_byte = CH_CR;
                        if (b != CH_CR) begin
                            n_cr = 1'b0; two = 1'b1;
                            e1.payload_valid = 1'b1; e1.payload_byte = b;
                        end
                    end
                end else if (b == CH_CR) begin
                    n_cr = 1'b1;
                end else begin
                    any = 1'b1; e0.payload_valid = 1'b1; e0.payload_byte = b;
                end
            end
            PH_BULK: begin
                any = 1'b1;
                e0.payload_valid = 1'b1; e0.payload_byte = b; e0.elem_type = ET_BULK;
                n_bulk = (r_bulk != '0) ? r_bulk - 1'b1 : r_bulk;
                if (n_bulk == '0) n_ph = PH_BULKEND;
            end
            PH_BULKEND: begin
                if (r_cr && b == CH_LF) begin
                    any = 1'b1; n_cr = 1'b0; n_ph = PH_TYPE; fin = 1'b1;
                    e0.elem_type = ET_BULK; e0.elem_done = 1'b1;
                    e0.length_value = {1'b0, r_acc}; e0.value_done = fin_vd;
                end else begin
                    n_cr = (b == CH_CR);
                end
            end
            default: begin
                n_ph = PH_ERROR; any = 1'b1;
            end
        endcase
        if (fin) begin
            n_sp = fin_sp;
            n_dec = !fin_vd;
        end
        if (n_ph == PH_ERROR) begin
            e0 = '0; two = 1'b0;
        end
        e0.nest_depth = 5'(n_sp); e0.error_code = n_err;
        e1.nest_depth = 5'(n_sp); e1.error_code = n_err;
        e0.last_of_run = !two; e1.last_of_run = 1'b1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ph <= PH_TYPE; r_ty <= '0; r_acc <= '0; r_neg <= 1'b0; r_dig <= 1'b0;
            r_bulk <= '0; r_cr <= 1'b0; r_sp <= '0; r_err <= ERR_NONE;
            r_one <= '0;
        end else if (acc) begin
            if (i_data.resync) begin
                r_ph <= PH_TYPE; r_ty <= '0; r_acc <= '0; r_neg <= 1'b0;
                r_dig <= 1'b0; r_bulk <= '0; r_cr <= 1'b0; r_sp <= '0;
                r_err <= ERR_NONE;
            end else begin
                r_ph <= n_ph; r_ty <= n_ty; r_acc <= n_acc; r_neg <= n_neg;
                r_dig <= n_dig; r_bulk <= n_bulk; r_cr <= n_cr; r_sp <= n_sp;
                r_err <= n_err;
                if (push_stk) r_one[IW'(r_sp)] <= (r_acc == 31'd1);
                if (n_dec) r_one[IW'(fin_sp - 1'b1)] <=
                    (r_stk[IW'(fin_sp - 1'b1)] == 31'd2);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (acc && !i_data.resync) begin
            if (push_stk) r_stk[IW'(r_sp)] <= r_acc;
            if (n_dec) r_stk[IW'(fin_sp - 1'b1)] <= r_stk[IW'(fin_sp - 1'b1)] - 1'b1;
        end
    end

    assign o_push = acc & !i_data.resync & any;
    assign o_ent  = '{two: two, r0: e0, r1: e1};
endmodule

/* rtl/core/rsp_back.sv */
// rsp_back: two-entry queue of per-byte results, drains one result per beat.
// Depends on rsp_pkg.
module rsp_back (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  rsp_pkg::t_ent i_ent,
    output logic          o_space,
    output logic          o_valid,
    output rsp_pkg::t_out o_data,
    input  logic          i_ready
);
    import rsp_pkg::*;

    t_ent r_q [2];
    logic r_wp, r_rp, n_wp, n_rp;
    logic [1:0] r_cnt, n_cnt;
    logic r_half, n_half;
    logic pop;

    assign o_valid = (r_cnt != 2'd0);
    assign o_data  = r_half ? r_q[r_rp].r1 : r_q[r_rp].r0;
    assign pop     = o_valid && i_ready && (r_half || !r_q[r_rp].two);
    // space when a slot is free or the head retires this cycle
    assign o_space = (r_cnt != 2'd2) || pop;

    always_comb begin
        n_wp = r_wp; n_rp = r_rp; n_half = r_half; n_cnt = r_cnt;
        if (o_valid && i_ready) begin
            if (pop) begin n_rp = !r_rp; n_half = 1'b0; end
            else n_half = 1'b1;
        end
        if (i_push) n_wp = !r_wp;
        n_cnt = r_cnt + 2'(i_push) - 2'(pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= 1'b0; r_rp <= 1'b0; r_cnt <= '0; r_half <= 1'b0;
        end else begin
            r_wp <= n_wp; r_rp <= n_rp; r_cnt <= n_cnt; r_half <= n_half;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) r_q[r_wp] <= i_ent;
    end
endmodule

/* bench/resp_stream_parser_checker.sv */
`timescale 1ns / 1ps
// resp_stream_parser_checker: watches both channels of the RESP parser, predicts
// the result beats of every accepted input beat and compares them in order.
// Depends on rsp_pkg.
module resp_stream_parser_checker (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    input  logic          i_in_ready,
    input  rsp_pkg::t_in  i_in_data,
    input  logic          i_out_valid,
    input  logic          i_out_ready,
    input  rsp_pkg::t_out i_out_data,
    output int            o_fail_count,
    output int            o_pending,
    output int            o_result_count
);
    import rsp_pkg::*;

    localparam int STACK_DEPTH = 16;

    t_phase      phase;
    logic [2:0]  cur_type;
    logic [31:0] len_acc;
    logic        len_neg;
    logic        got_digit;
    logic [31:0] bulk_left;
    logic        cr_seen;
    logic [31:0] level_left [STACK_DEPTH];
    logic [4:0]  depth;
    logic [2:0]  err_code;

    t_out expected_beats[$];
    t_out step_beats[$];

    assign o_pending = expected_beats.size();

    task automatic clear_parse();
        phase     = PH_TYPE;
        cur_type  = ET_ARRAY;
        len_acc   = '0;
        len_neg   = 1'b0;
        got_digit = 1'b0;
        bulk_left = '0;
        cr_seen   = 1'b0;
        depth     = '0;
        err_code  = ERR_NONE;
    endtask

    task automatic put(input logic pv, input logic [7:0] pb, input logic es,
                       input logic [2:0] et, input logic ed, input logic [31:0] lv,
                       input logic vd);
        t_out r;
        r.payload_valid = pv;
        r.payload_byte  = pb;
        r.elem_start    = es;
        r.elem_type     = et;
        r.elem_done     = ed;
        r.length_value  = lv;
        r.nest_depth    = depth;
        r.value_done    = vd;
        r.error_code    = err_code;
        r.last_of_run   = 1'b0;
        step_beats = {step_beats, r};
    endtask

    task automatic raise(input logic [2:0] code);
        err_code = code;
        phase    = PH_ERROR;
        put(0, 0, 0, ET_ARRAY, 0, 0, 0);
    endtask

    // count down enclosing arrays; returns 1 when a top-level value closed
    function automatic logic close_elem();
        while (depth > 0) begin
            if (level_left[4'(depth - 5'd1)] > 1) begin
                level_left[4'(depth - 5'd1)] = level_left[4'(depth - 5'd1)] - 1;
                return 1'b0;
            end
            depth = depth - 1;
        end
        return 1'b1;
    endfunction

    task automatic header_done();
        logic vd;
        cr_seen = 1'b0;
        if (!got_digit) begin
            raise(ERR_LENGTH);
        end else if (cur_type == ET_ARRAY) begin
            if (len_neg || len_acc == 0) begin
                phase = PH_TYPE;
                vd = close_elem();
                put(0, 0, 0, ET_ARRAY, 1, 0, vd);
            end else if (depth >= STACK_DEPTH) begin
                raise(ERR_DEPTH);
            end else begin
                level_left[4'(depth)] = len_acc;
                depth = depth + 1;
                phase = PH_TYPE;
                put(0, 0, 0, ET_ARRAY, 1, len_acc, 0);
            end
        end else if (len_neg && len_acc != 0) begin
            if (len_acc != 1) begin
                raise(ERR_NEG);
            end else begin
                phase = PH_TYPE;
                vd = close_elem();
                put(0, 0, 0, ET_NULL, 1, 32'hFFFF_FFFF, vd);
            end
        end else if (len_acc == 0) begin
            phase = PH_BULKEND;
        end else begin
            bulk_left = len_acc;
            phase = PH_BULK;
        end
    endtask

    task automatic predict_byte(input t_in beat);
        logic [7:0]  b;
        logic [31:0] d;
        logic        vd;
        b = beat.stream_byte;
        step_beats.delete();
        if (beat.resync) begin
            clear_parse();
            return;
        end
        case (phase)
            PH_TYPE: begin
                len_acc = '0;
                len_neg = 1'b0;
                got_digit = 1'b0;
                cr_seen = 1'b0;
                if (b == CH_STAR || b == CH_DOLLR || b == CH_PLUS || b == CH_COLON
                    || b == CH_MINUS) begin
                    if (b == CH_STAR) begin
                        cur_type = ET_ARRAY;
                        phase = PH_LEN;
                    end else if (b == CH_DOLLR) begin
                        cur_type = ET_BULK;
                        phase = PH_LEN;
                    end else if (b == CH_MINUS) begin
                        cur_type = ET_ERROR;
                        phase = PH_LINE;
                    end else begin
                        cur_type = ET_SIMPLE;
                        phase = PH_LINE;
                    end
                    put(0, 0, 1, cur_type, 0, 0, 0);
                end else begin
                    raise(ERR_TYPE);
                end
            end
            PH_LEN: begin
                if (cr_seen) begin
                    if (b == CH_LF) header_done();
                    else raise(ERR_LENGTH);
                end else if (b == CH_CR) begin
                    cr_seen = 1'b1;
                end else if (b == CH_MINUS && !got_digit && !len_neg) begin
                    len_neg = 1'b1;
                end else if (b >= CH_ZERO && b <= CH_NINE) begin
                    d = 32'(b - CH_ZERO);
                    if (len_acc > (32'h7FFF_FFFF - d) / 10) begin
                        raise(ERR_LENGTH);
                    end else begin
                        len_acc = len_acc * 10 + d;
                        got_digit = 1'b1;
                    end
                end else begin
                    raise(ERR_LENGTH);
                end
            end
            PH_LINE: begin
                if (cr_seen) begin
                    if (b == CH_LF) begin
                        cr_seen = 1'b0;
                        phase = PH_TYPE;
                        vd = close_elem();
                        put(0, 0, 0, cur_type, 1, 0, vd);
                    end else if (b == CH_CR) begin
                        put(1, CH_CR, 0, cur_type, 0, 0, 0);
                    end else begin
                        cr_seen = 1'b0;
                        put(1, CH_CR, 0, cur_type, 0, 0, 0);
                        put(1, b, 0, cur_type, 0, 0, 0);
                    end
                end else if (b == CH_CR) begin
                    cr_seen = 1'b1;
                end else begin
                    put(1, b, 0, cur_type, 0, 0, 0);
                end
            end
            PH_BULK: begin
                put(1, b, 0, ET_BULK, 0, 0, 0);
                if (bulk_left > 0) bulk_left = bulk_left - 1;
                if (bulk_left == 0) phase = PH_BULKEND;
            end
            PH_BULKEND: begin
                if (cr_seen && b == CH_LF) begin
                    cr_seen = 1'b0;
                    phase = PH_TYPE;
                    vd = close_elem();
                    put(0, 0, 0, ET_BULK, 1, len_acc, vd);
                end else begin
                    cr_seen = (b == CH_CR);
                end
            end
            default: begin
                phase = PH_ERROR;
                put(0, 0, 0, ET_ARRAY, 0, 0, 0);
            end
        endcase
        if (step_beats.size() > 0) step_beats[step_beats.size()-1].last_of_run = 1'b1;
        foreach (step_beats[k]) expected_beats = {expected_beats, step_beats[k]};
    endtask

    initial begin
        o_fail_count = 0;
        o_result_count = 0;
        clear_parse();
    end

    always @(posedge i_clk) begin
        t_out want;
        if (!i_rst_n) begin
            clear_parse();
            expected_beats.delete();
        end else begin
            if (i_out_valid && i_out_ready) begin
                o_result_count <= o_result_count + 1;
                if (expected_beats.size() == 0) begin
                    o_fail_count <= o_fail_count + 1;
                    if (o_fail_count < 10)
                        $display("%0t unexpected result beat %p", $realtime, i_out_data);
                end else begin
                    want = expected_beats.pop_front();
                    if (i_out_data.payload_valid !== want.payload_valid
                        || i_out_data.payload_byte !== want.payload_byte
                        || i_out_data.elem_start !== want.elem_start
                        || i_out_data.elem_type !== want.elem_type
                        || i_out_data.elem_done !== want.elem_done
                        || i_out_data.length_value !== want.length_value
                        || i_out_data.nest_depth !== want.nest_depth
                        || i_out_data.value_done !== want.value_done
                        || i_out_data.error_code !== want.error_code
                        || i_out_data.last_of_run !== want.last_of_run) begin
                        o_fail_count <= o_fail_count + 1;
                        if (o_fail_count < 10)
                            $display("%0t mismatch: expected %p got %p", $realtime,
                                     want, i_out_data);
                    end
                end
            end
            // predict after the pop so a same-cycle result is not taken for this beat
            if (i_in_valid && i_in_ready) predict_byte(i_in_data);
        end
    end
endmodule

/* bench/resp_stream_parser_top_test.sv */
`timescale 1ns / 1ps
// resp_stream_parser_top_test: drives RESP byte streams into the parser with
// random idling on both sides. Depends on rsp_pkg, resp_stream_parser_top and
// resp_stream_parser_checker.
module resp_stream_parser_top_test;
    import rsp_pkg::*;

    localparam int IDLE_LIMIT = 5000;

    logic  i_clk;
    logic  i_rst_n;
    logic  in_valid;
    t_in   in_data;
    logic  in_ready;
    logic  out_valid;
    t_out  out_data;
    logic  out_ready;
    int    fail_count;
    int    pending;
    int    result_count;
    int    send_gap_pct;
    int    stall_pct;
    int    bytes_sent;
    int    idle_cycles;

    resp_stream_parser_top u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .i_in_data   (in_data),
        .o_in_ready  (in_ready),
        .o_out_valid (out_valid),
        .o_out_data  (out_data),
        .i_out_ready (out_ready)
    );

    resp_stream_parser_checker u_checker (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (in_valid),
        .i_in_ready     (in_ready),
        .i_in_data      (in_data),
        .i_out_valid    (out_valid),
        .i_out_ready    (out_ready),
        .i_out_data     (out_data),
        .o_fail_count   (fail_count),
        .o_pending      (pending),
        .o_result_count (result_count)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    always @(posedge i_clk) out_ready <= ($urandom_range(99) >= stall_pct);

    always @(posedge i_clk) begin
        if (!i_rst_n || (in_valid && in_ready) || (out_valid && out_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    task automatic send_raw(input logic [7:0] b, input logic rs);
        while ($urandom_range(99) < send_gap_pct) begin
            in_valid <= 1'b0;
            @(posedge i_clk);
        end
        in_valid <= 1'b1;
        in_data  <= '{stream_byte: b, resync: rs};
        // ready is sampled at the edge itself, before the registers move
        @(posedge i_clk iff in_ready);
        bytes_sent++;
    endtask

    task automatic send_byte(input logic [7:0] b);
        send_raw(b, 1'b0);
    endtask

    task automatic send_str(input string s);
        for (int k = 0; k < s.len(); k++) send_byte(s[k]);
    endtask

    task automatic resync();
        send_raw(8'($urandom_range(255)), 1'b1);
    endtask

    task automatic send_crlf();
        send_byte(CH_CR);
        send_byte(CH_LF);
    endtask

    // line content with arbitrary bytes, never a CR LF pair inside
    task automatic send_line_body(input int n);
        logic [7:0] b;
        logic       prev_cr;
        prev_cr = 1'b0;
        for (int k = 0; k < n; k++) begin
            b = 8'($urandom_range(255));
            if ($urandom_range(9) == 0) b = CH_CR;
            if (prev_cr && b == CH_LF) b = 8'h78;
            send_byte(b);
            prev_cr = (b == CH_CR);
        end
    endtask

    task automatic send_value(input int level);
        int n;
        int pick;
        pick = $urandom_range(9);
        if (pick < 3 && level < 4) begin
            n = $urandom_range(0, 3);
            if ($urandom_range(7) == 0) n = -$urandom_range(1, 3);
            send_str($sformatf("*%0d", n));
            send_crlf();
            for (int k = 0; k < n; k++) send_value(level + 1);
        end else if (pick < 6) begin
            n = ($urandom_range(15) == 0) ? 20 : $urandom_range(0, 6);
            if ($urandom_range(9) == 0) begin
                send_str("$-1");
                send_crlf();
            end else begin
                send_str($sformatf("$%0d", n));
                send_crlf();
                for (int k = 0; k < n; k++) send_byte(8'($urandom_range(255)));
                if ($urandom_range(9) == 0) send_str("zz");
                send_crlf();
            end
        end else begin
            case ($urandom_range(2))
                0: send_byte(CH_PLUS);
                1: send_byte(CH_COLON);
                default: send_byte(CH_MINUS);
            endcase
            send_line_body($urandom_range(0, 5));
            send_crlf();
        end
    endtask

    task automatic send_noise();
        int n;
        n = $urandom_range(1, 6);
        for (int k = 0; k < n; k++) send_byte(8'($urandom_range(255)));
        resync();
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
    endtask

    task automatic run_phase(input int gap, input int stall, input int n_bytes);
        int stop_at;
        send_gap_pct = gap;
        stall_pct = stall;
        stop_at = bytes_sent + n_bytes;
        while (bytes_sent < stop_at) begin
            if ($urandom_range(9) == 0) send_noise();
            else send_value(0);
        end
    endtask

    initial begin
        i_rst_n = 1'b0;
        in_valid = 1'b0;
        in_data = '0;
        out_ready = 1'b0;
        send_gap_pct = 0;
        stall_pct = 0;
        bytes_sent = 0;
        idle_cycles = 0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: empty and negative arrays, null, bad negative bulk, "-0"
        send_str("*0"); send_crlf();
        send_str("*-1"); send_crlf();
        send_str("*-0"); send_crlf();
        send_str("$-1"); send_crlf();
        send_str("$0"); send_crlf(); send_crlf();
        send_str("+a\rb\r\r"); send_byte(CH_LF);
        send_str(":-42"); send_crlf();
        send_str("-ERR"); send_crlf();
        send_str("$-2"); send_crlf(); send_byte(CH_PLUS); resync();
        send_str("$2147483648"); resync();
        send_str("*2147483647"); send_byte(CH_CR); send_byte(8'hFF); resync();
        send_str("$"); send_crlf(); resync();
        send_byte(8'h21); send_byte(8'h00); resync();
        send_str("*--1"); resync();
        for (int k = 0; k < 16; k++) begin
            send_str("*1"); send_crlf();
        end
        send_str("*1"); send_crlf(); resync();
        for (int k = 0; k < 16; k++) begin
            send_str("*1"); send_crlf();
        end
        send_str("$3"); send_crlf(); send_str("\r\n\r"); send_crlf();

        // pause until every pending result has come out
        drain();

        run_phase(0, 0, 150);
        run_phase(50, 0, 150);
        drain();
        run_phase(0, 50, 150);
        run_phase(6, 6, 150);

        drain();
        repeat (20) @(posedge i_clk);
        $display("Sent %0d stream bytes with directed and random RESP values, noise and resyncs;",
                 bytes_sent);
        $display("checked %0d result beats across four idling mixes.", result_count);
        if (fail_count == 0 && pending == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end
endmodule

/* sim.f */
rtl/core/rsp_pkg.sv
rtl/core/rsp_front.sv
rtl/core/rsp_back.sv
rtl/core/resp_stream_parser_top.sv
bench/resp_stream_parser_checker.sv
bench/resp_stream_parser_top_test.sv
